// ----- sv/rdfc8_pkg.sv -----
// Shared types, protocol constants and the CRC8 step for the register datagram framer.
package rdfc8_pkg;

    // Protocol bytes
    localparam logic [7:0] SYNC_BYTE   = 8'h05;
    localparam logic [7:0] CRC_POLY    = 8'h07;
    localparam logic [7:0] WRITE_FLAG  = 8'h80;
    localparam logic [7:0] MASTER_ADDR = 8'hFF;

    // Configuration register indexes
    localparam logic CFG_NODE_ADDRESS = 1'b0;
    localparam logic CFG_SKIP_ECHO    = 1'b1;

    // Result word kinds (m_axis_tuser)
    localparam logic KIND_TX    = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    // Command opcodes on s_axis_tuser
    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_RX_BYTE = 2'd2
    } t_op;

    // Work handed from front to back
    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_REPLY = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  node;
        logic [6:0]  reg_addr;
        logic [31:0] value;     // write data, or reply value
        logic        ok;        // reply check result
    } t_cmd;

    // Index of the CRC byte in each outgoing datagram
    localparam logic [2:0] WRITE_LAST_IDX = 3'd7;
    localparam logic [2:0] READ_LAST_IDX  = 3'd3;

    // Fold one byte into the CRC, LSB first
    function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[7] ^ data[i];
            c  = {c[6:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

endpackage

// ----- sv/rdfc8_front.sv -----
// Front end: takes command words, holds configuration, tracks the reply receiver.
module rdfc8_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_index,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_accept,
    input  logic [1:0]        i_op,
    input  logic [6:0]        i_reg_address,
    input  logic [31:0]       i_write_value,
    input  logic [7:0]        i_rx_byte,
    output logic              o_push,
    output rdfc8_pkg::t_cmd   o_cmd
);

    logic [7:0]  r_node_address;
    logic        r_skip_echo;

    logic        r_awaiting, n_awaiting;
    logic [6:0]  r_expected_reg, n_expected_reg;
    logic [3:0]  r_rx_index, n_rx_index;
    logic [7:0]  r_rx_crc, n_rx_crc;
    logic        r_header_good, n_header_good;
    logic [31:0] r_value_shift, n_value_shift;

    logic [2:0]  w_k;
    logic        w_ok;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_address <= 8'h00;
            r_skip_echo    <= 1'b1;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                rdfc8_pkg::CFG_NODE_ADDRESS: r_node_address <= i_cfg_wdata;
                rdfc8_pkg::CFG_SKIP_ECHO:    r_skip_echo    <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Position within the reply: index 4 maps to reply byte 0
    assign w_k  = r_rx_index[2:0] + 3'd4;
    assign w_ok = r_header_good && (r_rx_crc == i_rx_byte);

    // Classify the word and advance the receiver
    always_comb begin
        n_awaiting     = r_awaiting;
        n_expected_reg = r_expected_reg;
        n_rx_index     = r_rx_index;
        n_rx_crc       = r_rx_crc;
        n_header_good  = r_header_good;
        n_value_shift  = r_value_shift;
        o_push         = 1'b0;
        o_cmd.kind     = rdfc8_pkg::CMD_WRITE;
        o_cmd.node     = r_node_address;
        o_cmd.reg_addr = i_reg_address;
        o_cmd.value    = i_write_value;
        o_cmd.ok       = 1'b0;
        if (i_accept) begin
            case (i_op)
                rdfc8_pkg::OP_WRITE: begin
                    o_push = 1'b1;
                end
                rdfc8_pkg::OP_READ: begin
                    o_push         = 1'b1;
                    o_cmd.kind     = rdfc8_pkg::CMD_READ;
                    n_awaiting     = 1'b1;
                    n_expected_reg = i_reg_address;
                    n_rx_index     = r_skip_echo ? 4'd0 : 4'd4;
                    n_rx_crc       = 8'h00;
                    n_header_good  = 1'b1;
                    n_value_shift  = 32'h0;
                end
                rdfc8_pkg::OP_RX_BYTE: begin
                    if (r_awaiting) begin
                        if (r_rx_index < 4'd4) begin
                            // drop echoed request byte
                            n_rx_index = r_rx_index + 4'd1;
                        end else if (w_k == 3'd7) begin
                            o_push         = 1'b1;
                            o_cmd.kind     = rdfc8_pkg::CMD_REPLY;
                            o_cmd.value    = w_ok ? r_value_shift : 32'h0;
                            o_cmd.ok       = w_ok;
                            n_awaiting     = 1'b0;
                            n_rx_index     = 4'd0;
                            n_rx_crc       = 8'h00;
                            n_header_good  = 1'b1;
                            n_value_shift  = 32'h0;
                        end else begin
                            if (w_k == 3'd0 && i_rx_byte != rdfc8_pkg::SYNC_BYTE) begin
                                n_header_good = 1'b0;
                            end
                            if (w_k == 3'd1 && i_rx_byte != rdfc8_pkg::MASTER_ADDR) begin
                                n_header_good = 1'b0;
                            end
                            if (w_k == 3'd2 && i_rx_byte != {1'b0, r_expected_reg}) begin
                                n_header_good = 1'b0;
                            end
                            if (w_k >= 3'd3) begin
                                n_value_shift = {r_value_shift[23:0], i_rx_byte};
                            end
                            n_rx_crc   = rdfc8_pkg::crc8_feed(r_rx_crc, i_rx_byte);
                            n_rx_index = r_rx_index + 4'd1;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting     <= 1'b0;
            r_expected_reg <= 7'h00;
            r_rx_index     <= 4'd0;
            r_rx_crc       <= 8'h00;
            r_header_good  <= 1'b1;
            r_value_shift  <= 32'h0;
        end else begin
            r_awaiting     <= n_awaiting;
            r_expected_reg <= n_expected_reg;
            r_rx_index     <= n_rx_index;
            r_rx_crc       <= n_rx_crc;
            r_header_good  <= n_header_good;
            r_value_shift  <= n_value_shift;
        end
    end

    // A reply always disarms the receiver
    a_reply_disarms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push && o_cmd.kind == rdfc8_pkg::CMD_REPLY |=> !r_awaiting)
        else $error("receiver still armed after reply");

endmodule

// ----- sv/rdfc8_cmd_fifo.sv -----
// Command queue between front end and datagram back end.
module rdfc8_cmd_fifo #(
    parameter int DEPTH = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rdfc8_pkg::t_cmd   i_cmd,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_valid,
    output rdfc8_pkg::t_cmd   o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    rdfc8_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            w_do_pop;

    assign o_full   = (r_count == CW'(DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_cmd    = r_mem[r_rd_ptr];
    assign w_do_pop = i_pop && o_valid;

    // Store entries
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && w_do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full command queue");

endmodule

// ----- sv/rdfc8_back.sv -----
// Back end: serializes datagrams with CRC8 and drives the result output register.
module rdfc8_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  rdfc8_pkg::t_cmd   i_cmd,
    output logic              o_pop,
    output logic              o_tvalid,
    input  logic              i_tready,
    output logic              o_tuser,
    output logic              o_tlast,
    output logic [47:0]       o_tdata
);

    logic [2:0]  r_idx, n_idx;
    logic [7:0]  r_crc, n_crc;
    logic        r_tvalid, n_tvalid;
    logic        r_tuser, n_tuser;
    logic        r_tlast, n_tlast;
    logic [47:0] r_tdata, n_tdata;

    logic        w_adv;
    logic        w_is_write;
    logic [2:0]  w_last_idx;
    logic        w_is_last;
    logic [7:0]  w_byte;
    logic [7:0]  w_byte_out;

    assign w_adv      = !r_tvalid || i_tready;
    assign w_is_write = (i_cmd.kind == rdfc8_pkg::CMD_WRITE);
    assign w_last_idx = w_is_write ? rdfc8_pkg::WRITE_LAST_IDX : rdfc8_pkg::READ_LAST_IDX;
    assign w_is_last  = (r_idx == w_last_idx);
    assign w_byte_out = w_is_last ? r_crc : w_byte;

    // Pick the datagram byte at the current position
    always_comb begin
        case (r_idx)
            3'd0:    w_byte = rdfc8_pkg::SYNC_BYTE;
            3'd1:    w_byte = i_cmd.node;
            3'd2:    w_byte = w_is_write ? ({1'b0, i_cmd.reg_addr} | rdfc8_pkg::WRITE_FLAG)
                                         : {1'b0, i_cmd.reg_addr};
            3'd3:    w_byte = w_is_write ? i_cmd.value[31:24] : 8'h00;
            3'd4:    w_byte = i_cmd.value[23:16];
            3'd5:    w_byte = i_cmd.value[15:8];
            3'd6:    w_byte = i_cmd.value[7:0];
            default: w_byte = 8'h00;
        endcase
    end

    // Emit one word per cycle while the output slot frees up
    always_comb begin
        n_idx    = r_idx;
        n_crc    = r_crc;
        n_tvalid = r_tvalid;
        n_tuser  = r_tuser;
        n_tlast  = r_tlast;
        n_tdata  = r_tdata;
        o_pop    = 1'b0;
        if (i_cmd_valid && w_adv) begin
            n_tvalid = 1'b1;
            if (i_cmd.kind == rdfc8_pkg::CMD_REPLY) begin
                o_pop   = 1'b1;
                n_tuser = rdfc8_pkg::KIND_REPLY;
                n_tlast = 1'b0;
                n_tdata = {7'h00, i_cmd.ok, i_cmd.value, 8'h00};
            end else begin
                n_tuser = rdfc8_pkg::KIND_TX;
                n_tlast = w_is_last;
                n_tdata = {7'h00, 1'b0, 32'h0, w_byte_out};
                if (w_is_last) begin
                    o_pop = 1'b1;
                    n_idx = 3'd0;
                    n_crc = 8'h00;
                end else begin
                    n_idx = r_idx + 3'd1;
                    n_crc = rdfc8_pkg::crc8_feed(r_crc, w_byte);
                end
            end
        end else if (i_tready) begin
            n_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= 3'd0;
            r_crc    <= 8'h00;
            r_tvalid <= 1'b0;
        end else begin
            r_idx    <= n_idx;
            r_crc    <= n_crc;
            r_tvalid <= n_tvalid;
        end
    end

    // Hold payload
    always_ff @(posedge i_clk) begin
        r_tuser <= n_tuser;
        r_tlast <= n_tlast;
        r_tdata <= n_tdata;
    end

    assign o_tvalid = r_tvalid;
    assign o_tuser  = r_tuser;
    assign o_tlast  = r_tlast;
    assign o_tdata  = r_tdata;

    a_frame_head_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx != 3'd0 |-> i_cmd_valid)
        else $error("datagram in progress without its command");

    a_last_is_tx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tvalid && r_tlast |-> r_tuser == rdfc8_pkg::KIND_TX)
        else $error("end-of-datagram flag on a reply word");

endmodule

// ----- sv/register_datagram_framer_crc8_core.sv -----
// Top level of the register datagram framer: front end, command queue and back end.
// The input side takes one word per cycle as long as the command queue has room; a received
// line byte only updates the reply checker and queues nothing until the last reply byte.
// The back end sends one output word per cycle while m_axis_tready allows: a write command
// yields eight bytes, a read request four bytes and a completed reply one word, so a steady
// stream of writes is paced by the byte serializer.
// CRC8 (polynomial 0x07, init 0, LSB first) is folded one byte per output word.
module register_datagram_framer_crc8_core #(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,     // 0 node_address, 1 skip_echo
    input  logic [7:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [1:0]  s_axis_tuser,    // op
    input  logic [47:0] s_axis_tdata,    // reg_address[6:0], write_value[38:7], rx_byte[46:39]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic        m_axis_tuser,    // kind
    output logic        m_axis_tlast,    // last
    output logic [47:0] m_axis_tdata     // tx_byte[7:0], read_value[39:8], read_ok[40]
);

    logic            w_accept;
    logic            w_push;
    rdfc8_pkg::t_cmd w_push_cmd;
    logic            w_full;
    logic            w_head_valid;
    rdfc8_pkg::t_cmd w_head_cmd;
    logic            w_pop;

    assign s_axis_tready = !w_full;
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    rdfc8_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_accept      (w_accept),
        .i_op          (s_axis_tuser),
        .i_reg_address (s_axis_tdata[6:0]),
        .i_write_value (s_axis_tdata[38:7]),
        .i_rx_byte     (s_axis_tdata[46:39]),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    rdfc8_cmd_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_head_valid),
        .o_cmd   (w_head_cmd)
    );

    rdfc8_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_head_valid),
        .i_cmd       (w_head_cmd),
        .o_pop       (w_pop),
        .o_tvalid    (m_axis_tvalid),
        .i_tready    (m_axis_tready),
        .o_tuser     (m_axis_tuser),
        .o_tlast     (m_axis_tlast),
        .o_tdata     (m_axis_tdata)
    );

endmodule
